>>> hw/rtl/sbrcd_pkg.sv
// Shared types and constants for the sound-chip bus remap and cycle delay block.
package sbrcd_pkg;

  localparam int NUM_CHIPS   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  UNMAPPED     = 8'hFE;
  localparam logic [15:0] FM_ADDR_A    = 16'hDF40;
  localparam logic [15:0] FM_ADDR_B    = 16'hDF50;
  localparam logic [15:0] MIRROR_LO    = 16'hD5C0;
  localparam logic [15:0] MIRROR_HI    = 16'hD5DF;
  localparam logic [16:0] WIN_SPAN     = 17'h0001F;
  localparam logic [16:0] FOLD         = 17'h0FFFF;
  localparam logic [2:0]  CHIP_FM_NONE = 3'd5;

  localparam logic [2:0]  RST_CHIP_COUNT  = 3'd1;
  localparam logic [15:0] RST_BASE_ONE    = 16'hD400;
  localparam logic [15:0] RST_BASE_TWO    = 16'hD420;
  localparam logic [15:0] RST_BASE_THREE  = 16'hD440;
  localparam logic [15:0] RST_BASE_FOUR   = 16'hD460;
  localparam logic [7:0]  RST_FM_SEL      = 8'd0;
  localparam logic        RST_FORCE_SEC   = 1'b0;
  localparam logic [7:0]  RST_FIRST_CHIPS = 8'd1;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_CHIP_COUNT  = 3'd0,
    REG_BASE_ONE    = 3'd1,
    REG_BASE_TWO    = 3'd2,
    REG_BASE_THREE  = 3'd3,
    REG_BASE_FOUR   = 3'd4,
    REG_FM_SEL      = 3'd5,
    REG_FORCE_SEC   = 3'd6,
    REG_FIRST_CHIPS = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]                 chip_count;
    logic [NUM_CHIPS-1:0][15:0] base;
    logic [7:0]                 fm_sel;
    logic                       force_sec;
    logic [7:0]                 first_chips;
  } cfg_t;

  typedef struct packed {
    req_t        req;
    logic [7:0]  phys;
    logic [2:0]  chip;
    logic        mapped;
    logic [7:0]  value;
    logic [31:0] now;
  } job_t;

endpackage

>>> hw/rtl/sbrcd_ifs.sv
// Valid/ready channel interfaces for bus requests and remap results.
interface sbrcd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] bus_address;
  logic [7:0]  write_value;
  logic [31:0] cycle_now;

  modport source (output valid, req_type, bus_address, write_value, cycle_now, input ready);
  modport sink (input valid, req_type, bus_address, write_value, cycle_now, output ready);
endinterface

interface sbrcd_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  phys_address;
  logic [2:0]  chip_number;
  logic        is_mapped;
  logic [15:0] delay_cycles;
  logic [16:0] full_waits;
  logic        send_wait;
  logic        send_write;
  logic [7:0]  out_value;

  modport source (output valid, phys_address, chip_number, is_mapped, delay_cycles,
                  full_waits, send_wait, send_write, out_value, input ready);
  modport sink (input valid, phys_address, chip_number, is_mapped, delay_cycles,
                full_waits, send_wait, send_write, out_value, output ready);
endinterface

>>> hw/rtl/sbrcd_regs.sv
// APB configuration register file.
module sbrcd_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sbrcd_pkg::cfg_t   cfg
);

  sbrcd_pkg::cfg_t      cfg_r;
  sbrcd_pkg::reg_idx_t  idx;
  logic                 wr_en;

  assign idx    = sbrcd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chip_count  <= sbrcd_pkg::RST_CHIP_COUNT;
      cfg_r.base[0]     <= sbrcd_pkg::RST_BASE_ONE;
      cfg_r.base[1]     <= sbrcd_pkg::RST_BASE_TWO;
      cfg_r.base[2]     <= sbrcd_pkg::RST_BASE_THREE;
      cfg_r.base[3]     <= sbrcd_pkg::RST_BASE_FOUR;
      cfg_r.fm_sel      <= sbrcd_pkg::RST_FM_SEL;
      cfg_r.force_sec   <= sbrcd_pkg::RST_FORCE_SEC;
      cfg_r.first_chips <= sbrcd_pkg::RST_FIRST_CHIPS;
    end else if (wr_en) begin
      unique case (idx)
        sbrcd_pkg::REG_CHIP_COUNT:  cfg_r.chip_count  <= pwdata[2:0];
        sbrcd_pkg::REG_BASE_ONE:    cfg_r.base[0]     <= pwdata[15:0];
        sbrcd_pkg::REG_BASE_TWO:    cfg_r.base[1]     <= pwdata[15:0];
        sbrcd_pkg::REG_BASE_THREE:  cfg_r.base[2]     <= pwdata[15:0];
        sbrcd_pkg::REG_BASE_FOUR:   cfg_r.base[3]     <= pwdata[15:0];
        sbrcd_pkg::REG_FM_SEL:      cfg_r.fm_sel      <= pwdata[7:0];
        sbrcd_pkg::REG_FORCE_SEC:   cfg_r.force_sec   <= pwdata[0];
        sbrcd_pkg::REG_FIRST_CHIPS: cfg_r.first_chips <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sbrcd_pkg::REG_CHIP_COUNT:  prdata = {29'd0, cfg_r.chip_count};
      sbrcd_pkg::REG_BASE_ONE:    prdata = {16'd0, cfg_r.base[0]};
      sbrcd_pkg::REG_BASE_TWO:    prdata = {16'd0, cfg_r.base[1]};
      sbrcd_pkg::REG_BASE_THREE:  prdata = {16'd0, cfg_r.base[2]};
      sbrcd_pkg::REG_BASE_FOUR:   prdata = {16'd0, cfg_r.base[3]};
      sbrcd_pkg::REG_FM_SEL:      prdata = {24'd0, cfg_r.fm_sel};
      sbrcd_pkg::REG_FORCE_SEC:   prdata = {31'd0, cfg_r.force_sec};
      sbrcd_pkg::REG_FIRST_CHIPS: prdata = {24'd0, cfg_r.first_chips};
    endcase
  end

endmodule

>>> hw/rtl/sbrcd_front.sv
// Front end: accepts requests, decodes bus address, tracks the current chip.
module sbrcd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sbrcd_pkg::cfg_t   cfg,
  sbrcd_req_if.sink         in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output sbrcd_pkg::job_t   push_data
);

  logic [2:0]                          cur_chip_r;
  logic [2:0]                          chip_nxt;
  logic [7:0]                          phys;
  logic [15:0]                         addr;
  logic [4:0]                          low;
  logic [sbrcd_pkg::NUM_CHIPS-1:0]     win_hit;
  logic                                fm_hit;
  logic                                mirror;
  logic                                decoding;
  logic [1:0]                          sock;
  sbrcd_pkg::req_t                     req;

  assign addr = in_ch.bus_address;
  assign low  = addr[4:0];
  assign req  = sbrcd_pkg::req_t'(in_ch.req_type);
  assign decoding = (req == sbrcd_pkg::REQ_READ) || (req == sbrcd_pkg::REQ_WRITE);

  always_comb begin
    for (int k = 0; k < sbrcd_pkg::NUM_CHIPS; k++) begin
      win_hit[k] = (addr >= cfg.base[k]) &&
                   ({1'b0, addr} < ({1'b0, cfg.base[k]} + sbrcd_pkg::WIN_SPAN));
    end
    fm_hit = (addr == sbrcd_pkg::FM_ADDR_A) || (addr == sbrcd_pkg::FM_ADDR_B);
    mirror = (addr >= sbrcd_pkg::MIRROR_LO) && (addr <= sbrcd_pkg::MIRROR_HI);
    sock = 2'd0;
    if (cfg.force_sec) begin
      priority if (cfg.first_chips == 8'd1) sock = 2'd1;
      else if (cfg.first_chips == 8'd2) sock = 2'd2;
      else sock = 2'd0;
    end

    phys     = sbrcd_pkg::UNMAPPED;
    chip_nxt = cur_chip_r;
    if (decoding) begin
      priority if (fm_hit) begin
        if (cfg.fm_sel >= 8'd1 && cfg.fm_sel <= 8'd4) begin
          chip_nxt = cfg.fm_sel[2:0];
          phys     = {1'b0, cfg.fm_sel[1:0] - 2'd1, low};
        end else begin
          chip_nxt = sbrcd_pkg::CHIP_FM_NONE;
          phys     = {3'b100, low};
        end
      end else if (cfg.chip_count == 3'd1) begin
        if (win_hit[0] || mirror) begin
          chip_nxt = 3'd1;
          phys     = {1'b0, sock, low};
        end
      end else if (cfg.chip_count >= 3'd2 && cfg.chip_count <= 3'd4) begin
        // descending so the lowest matching window wins
        for (int k = sbrcd_pkg::NUM_CHIPS - 1; k >= 0; k--) begin
          if (win_hit[k] && (3'(k) < cfg.chip_count)) begin
            chip_nxt = 3'(k + 1);
            phys     = {1'b0, 2'(k), low};
          end
        end
      end else begin
        phys = sbrcd_pkg::UNMAPPED;
      end
    end
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_data.req    = req;
    push_data.phys   = phys;
    push_data.chip   = chip_nxt;
    push_data.mapped = (phys != sbrcd_pkg::UNMAPPED);
    push_data.value  = in_ch.write_value;
    push_data.now    = in_ch.cycle_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_chip_r <= 3'd0;
    end else if (push_valid && push_ready) begin
      cur_chip_r <= chip_nxt;
    end
  end

  a_mapped_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (push_data.mapped == (push_data.phys != sbrcd_pkg::UNMAPPED)))
    else $error("mapped flag disagrees with physical address");

  a_nondecode_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !decoding) |-> (!push_data.mapped && push_data.chip == cur_chip_r))
    else $error("flush or reserved request changed the decode");

endmodule

>>> hw/rtl/sbrcd_fifo.sv
// Short queue between front and back ends.
module sbrcd_fifo #(
  parameter int DEPTH = sbrcd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  sbrcd_pkg::job_t   push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output sbrcd_pkg::job_t   pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sbrcd_pkg::job_t  mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue occupancy out of range");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue count missed a transfer");

endmodule

>>> hw/rtl/sbrcd_back.sv
// Back end: cycle delay tracking, fold by 65535 and result register.
module sbrcd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  sbrcd_pkg::job_t   pop_data,
  sbrcd_rsp_if.source       out_ch
);

  typedef struct packed {
    logic [31:0] delta;
    logic        fold_en;
    logic        waits_en;
    logic        swait;
    logic        swrite;
    logic [7:0]  oval;
    logic [7:0]  phys;
    logic [2:0]  chip;
    logic        mapped;
  } stage_t;

  logic [31:0] last_cycle_r, last_cycle_nxt;
  logic        wds_r, wds_nxt;
  logic        s1_v_r, out_v_r;
  stage_t      s1_r, s1_nxt;
  logic        adv_out, s1_ready, pop;
  logic [31:0] delta;
  logic        flush_wait;

  logic [16:0] fsum;
  logic        over;
  logic [15:0] folded;
  logic [16:0] quot;

  logic [7:0]  phys_r, oval_r;
  logic [2:0]  chip_r;
  logic        mapped_r, swait_r, swrite_r;
  logic [15:0] delay_r;
  logic [16:0] waits_r;

  assign adv_out   = !out_v_r || out_ch.ready;
  assign s1_ready  = !s1_v_r || adv_out;
  assign pop_ready = s1_ready;
  assign pop       = pop_valid && s1_ready;

  assign delta      = pop_data.now - last_cycle_r;
  assign flush_wait = (pop_data.now >= last_cycle_r) && wds_r;

  always_comb begin
    s1_nxt.delta    = delta;
    s1_nxt.fold_en  = 1'b0;
    s1_nxt.waits_en = 1'b0;
    s1_nxt.swait    = 1'b0;
    s1_nxt.swrite   = 1'b0;
    s1_nxt.oval     = 8'd0;
    s1_nxt.phys     = pop_data.phys;
    s1_nxt.chip     = pop_data.chip;
    s1_nxt.mapped   = pop_data.mapped;
    last_cycle_nxt  = last_cycle_r;
    wds_nxt         = wds_r;
    unique case (pop_data.req)
      sbrcd_pkg::REQ_READ: begin
        s1_nxt.fold_en  = 1'b1;
        s1_nxt.waits_en = 1'b1;
        last_cycle_nxt  = pop_data.now;
      end
      sbrcd_pkg::REQ_WRITE: begin
        s1_nxt.fold_en  = 1'b1;
        s1_nxt.waits_en = 1'b1;
        s1_nxt.swait    = pop_data.mapped;
        s1_nxt.swrite   = pop_data.mapped;
        s1_nxt.oval     = pop_data.mapped ? pop_data.value : 8'd0;
        last_cycle_nxt  = pop_data.now;
        if (delta != 32'd0) wds_nxt = 1'b1;
      end
      sbrcd_pkg::REQ_FLUSH: begin
        s1_nxt.fold_en = flush_wait;
        s1_nxt.swait   = flush_wait;
        last_cycle_nxt = pop_data.now;
        wds_nxt        = 1'b0;
      end
      sbrcd_pkg::REQ_RSVD: begin
      end
    endcase
  end

  // d = hi*65535 + (hi + lo): one conditional subtract gives 1..65535 for d != 0
  always_comb begin
    fsum   = {1'b0, s1_r.delta[31:16]} + {1'b0, s1_r.delta[15:0]};
    over   = fsum[16];
    folded = over ? 16'(fsum - sbrcd_pkg::FOLD) : fsum[15:0];
    quot   = {1'b0, s1_r.delta[31:16]} + {16'd0, over};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cycle_r <= 32'd0;
      wds_r        <= 1'b0;
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (pop) begin
        last_cycle_r <= last_cycle_nxt;
        wds_r        <= wds_nxt;
      end
      if (s1_ready) s1_v_r <= pop_valid;
      if (adv_out)  out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) s1_r <= s1_nxt;
    if (adv_out && s1_v_r) begin
      phys_r   <= s1_r.phys;
      chip_r   <= s1_r.chip;
      mapped_r <= s1_r.mapped;
      delay_r  <= s1_r.fold_en ? folded : 16'd0;
      waits_r  <= (s1_r.fold_en && s1_r.waits_en) ? quot : 17'd0;
      swait_r  <= s1_r.swait;
      swrite_r <= s1_r.swrite;
      oval_r   <= s1_r.oval;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.phys_address = phys_r;
  assign out_ch.chip_number  = chip_r;
  assign out_ch.is_mapped    = mapped_r;
  assign out_ch.delay_cycles = delay_r;
  assign out_ch.full_waits   = waits_r;
  assign out_ch.send_wait    = swait_r;
  assign out_ch.send_write   = swrite_r;
  assign out_ch.out_value    = oval_r;

  a_write_needs_map: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && swrite_r) |-> (mapped_r && swait_r))
    else $error("forwarded write without mapped address and wait");

  a_zero_delay_no_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && delay_r == 16'd0) |-> (waits_r == 17'd0))
    else $error("full waits reported with zero delay");

endmodule

>>> hw/rtl/sid_bus_remap_and_cycle_delay.sv
// Top level of the sound-chip bus remap and cycle delay block.
// Takes one request transfer per clock while the queue has room and returns exactly
// one result transfer per request, in order. A request decodes in the front end in the
// cycle it is taken, waits in a short queue, then passes two back-end registers (delay
// measurement, then fold and result register). With the output not stalled, the
// sustained rate of one transfer per cycle is set by the back end's update of the
// last-cycle count. Configuration registers sit on the APB port at byte address
// 4*index; the user is to write them only while the block holds no request in flight,
// as the block itself does not enforce this.
module sid_bus_remap_and_cycle_delay #(
  parameter int QUEUE_DEPTH = sbrcd_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  sbrcd_req_if.sink    in_ch,
  sbrcd_rsp_if.source  out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  sbrcd_pkg::cfg_t  cfg;
  sbrcd_pkg::job_t  push_data, pop_data;
  logic             push_valid, push_ready, pop_valid, pop_ready;

  sbrcd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbrcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sbrcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sbrcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the bus remap and cycle delay block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [7:0]  phys;
    logic [2:0]  chip;
    logic        mapped;
    logic [15:0] delay;
    logic [16:0] waits;
    logic        swait;
    logic        swrite;
    logic [7:0]  oval;
  } remap_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sbrcd_req_if req_ch ();
  sbrcd_rsp_if rsp_ch ();

  sid_bus_remap_and_cycle_delay i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow configuration and predictor state
  logic [2:0]  cfg_chips;
  logic [15:0] cfg_base [4];
  logic [7:0]  cfg_fm_sel;
  logic        cfg_force_sec;
  logic [7:0]  cfg_first_chips;
  logic [31:0] prev_cycle;
  logic [2:0]  cur_chip;
  logic        wrote_delay;

  remap_rsp_t  pending_rsp [$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 15;
  int          recv_idle_pct = 84;
  logic [31:0] bus_cycle = '0;
  bit          hold_tog = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready  <= 1'b0;
    end else if (hold_tog != hold_seen) begin
      hold_seen     <= hold_tog;
      hold_left     <= HOLD_CYCLES;
      rsp_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_ch.ready  <= 1'b0;
    end else begin
      rsp_ch.ready  <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic in_window(input logic [15:0] addr, input logic [15:0] base);
    return ({1'b0, addr} >= {1'b0, base}) &&
           ({1'b0, addr} < ({1'b0, base} + sbrcd_pkg::WIN_SPAN));
  endfunction

  function automatic logic [15:0] fold_delay(input logic [31:0] d, output logic [16:0] waits);
    logic [31:0] r;
    waits = '0;
    if (d == 0) return '0;
    r = d % 32'(sbrcd_pkg::FOLD);
    if (r == 0) r = 32'(sbrcd_pkg::FOLD);
    waits = 17'((d - r) / 32'(sbrcd_pkg::FOLD));
    return r[15:0];
  endfunction

  function automatic remap_rsp_t predict_access(input sbrcd_pkg::req_t req,
                                                input logic [15:0] addr,
                                                input logic [7:0] val, input logic [31:0] now);
    remap_rsp_t  rsp;
    logic [7:0]  phys;
    logic [7:0]  sel_m1;
    logic [7:0]  off;
    logic [4:0]  low;
    logic [16:0] unused_waits;
    logic        hit;
    rsp  = '0;
    phys = sbrcd_pkg::UNMAPPED;
    low  = addr[4:0];
    hit  = 1'b0;
    case (req)
      sbrcd_pkg::REQ_READ, sbrcd_pkg::REQ_WRITE: begin
        if (addr == sbrcd_pkg::FM_ADDR_A || addr == sbrcd_pkg::FM_ADDR_B) begin
          if (cfg_fm_sel >= 8'd1 && cfg_fm_sel <= 8'd4) begin
            sel_m1   = cfg_fm_sel - 8'd1;
            cur_chip = cfg_fm_sel[2:0];
            phys     = {1'b0, sel_m1[1:0], low};
          end else begin
            cur_chip = sbrcd_pkg::CHIP_FM_NONE;
            phys     = {3'b100, low};
          end
        end else if (cfg_chips == 3'd1) begin
          if (in_window(addr, cfg_base[0]) ||
              (addr >= sbrcd_pkg::MIRROR_LO && addr <= sbrcd_pkg::MIRROR_HI)) begin
            off = 8'h00;
            if (cfg_force_sec) begin
              if (cfg_first_chips == 8'd1) off = 8'h20;
              else if (cfg_first_chips == 8'd2) off = 8'h40;
            end
            cur_chip = 3'd1;
            phys     = off + {3'b000, low};
          end
        end else if (cfg_chips >= 3'd2 && cfg_chips <= 3'd4) begin
          for (int k = 0; k < 4; k++) begin
            if (!hit && k < int'(cfg_chips) && in_window(addr, cfg_base[k])) begin
              hit      = 1'b1;
              cur_chip = 3'(k + 1);
              phys     = {1'b0, k[1:0], low};
            end
          end
        end
        rsp.delay  = fold_delay(now - prev_cycle, rsp.waits);
        prev_cycle = now;
        if (req == sbrcd_pkg::REQ_WRITE) begin
          if (phys != sbrcd_pkg::UNMAPPED) begin
            rsp.swait  = 1'b1;
            rsp.swrite = 1'b1;
            rsp.oval   = val;
          end
          if (rsp.delay != 0) wrote_delay = 1'b1;
        end
      end
      sbrcd_pkg::REQ_FLUSH: begin
        if (!(now < prev_cycle || !wrote_delay)) begin
          rsp.delay = fold_delay(now - prev_cycle, unused_waits);
          rsp.swait = 1'b1;
        end
        prev_cycle  = now;
        wrote_delay = 1'b0;
      end
      default: begin
      end
    endcase
    rsp.phys   = phys;
    rsp.chip   = cur_chip;
    rsp.mapped = (phys != sbrcd_pkg::UNMAPPED);
    return rsp;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    remap_rsp_t exp_rsp;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, phys %0h", $time,
                 rsp_ch.phys_address);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        check_field("phys_address", 32'(exp_rsp.phys), 32'(rsp_ch.phys_address));
        check_field("chip_number", 32'(exp_rsp.chip), 32'(rsp_ch.chip_number));
        check_field("is_mapped", 32'(exp_rsp.mapped), 32'(rsp_ch.is_mapped));
        check_field("delay_cycles", 32'(exp_rsp.delay), 32'(rsp_ch.delay_cycles));
        check_field("full_waits", 32'(exp_rsp.waits), 32'(rsp_ch.full_waits));
        check_field("send_wait", 32'(exp_rsp.swait), 32'(rsp_ch.send_wait));
        check_field("send_write", 32'(exp_rsp.swrite), 32'(rsp_ch.send_write));
        check_field("out_value", 32'(exp_rsp.oval), 32'(rsp_ch.out_value));
      end
    end
  end

  task automatic send_access(input sbrcd_pkg::req_t req, input logic [15:0] addr,
                             input logic [7:0] val, input logic [31:0] now);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= req;
    req_ch.bus_address <= addr;
    req_ch.write_value <= val;
    req_ch.cycle_now   <= now;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(predict_access(req, addr, val, now));
    bus_cycle = now;
  endtask

  task automatic wait_results_done();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sbrcd_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sbrcd_pkg::REG_CHIP_COUNT:  cfg_chips       = value[2:0];
      sbrcd_pkg::REG_BASE_ONE:    cfg_base[0]     = value[15:0];
      sbrcd_pkg::REG_BASE_TWO:    cfg_base[1]     = value[15:0];
      sbrcd_pkg::REG_BASE_THREE:  cfg_base[2]     = value[15:0];
      sbrcd_pkg::REG_BASE_FOUR:   cfg_base[3]     = value[15:0];
      sbrcd_pkg::REG_FM_SEL:      cfg_fm_sel      = value[7:0];
      sbrcd_pkg::REG_FORCE_SEC:   cfg_force_sec   = value[0];
      sbrcd_pkg::REG_FIRST_CHIPS: cfg_first_chips = value[7:0];
    endcase
    @(posedge clk);
  endtask

  // mostly decodable accesses with small steps, plus flushes, big jumps and noise
  task automatic send_random(input int n);
    int              sent;
    int              pick;
    sbrcd_pkg::req_t req;
    logic [15:0]     addr;
    logic [31:0]     now;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) req = sbrcd_pkg::REQ_WRITE;
      else if (pick < 80) req = sbrcd_pkg::REQ_READ;
      else if (pick < 96) req = sbrcd_pkg::REQ_FLUSH;
      else req = sbrcd_pkg::REQ_RSVD;
      pick = $urandom_range(0, 99);
      if (pick < 60) addr = cfg_base[$urandom_range(0, 3)] + 16'($urandom_range(0, 32));
      else if (pick < 72) addr = $urandom_range(0, 1) ? sbrcd_pkg::FM_ADDR_A
                                                      : sbrcd_pkg::FM_ADDR_B;
      else if (pick < 82) addr = sbrcd_pkg::MIRROR_LO - 16'd2 + 16'($urandom_range(0, 35));
      else addr = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 10) now = bus_cycle;
      else if (pick < 75) now = bus_cycle + $urandom_range(1, 300);
      else if (pick < 90) now = bus_cycle + $urandom_range(65000, 140000);
      else if (pick < 95) now = $urandom;
      else now = bus_cycle - $urandom_range(1, 1000);
      send_access(req, addr, 8'($urandom_range(0, 255)), now);
      sent++;
    end
  endtask

  task automatic write_random_config();
    logic [15:0] b0;
    b0 = 16'($urandom_range(0, 65535));
    write_reg(sbrcd_pkg::REG_CHIP_COUNT, ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                                     : $urandom_range(0, 7));
    if ($urandom_range(0, 1)) begin
      write_reg(sbrcd_pkg::REG_BASE_ONE, 32'(b0));
      write_reg(sbrcd_pkg::REG_BASE_TWO, 32'(16'(b0 + 16'h20)));
      write_reg(sbrcd_pkg::REG_BASE_THREE, 32'(16'(b0 + 16'h40)));
      write_reg(sbrcd_pkg::REG_BASE_FOUR, 32'(16'(b0 + 16'h60)));
    end else begin
      write_reg(sbrcd_pkg::REG_BASE_ONE, $urandom_range(0, 65535));
      write_reg(sbrcd_pkg::REG_BASE_TWO, $urandom_range(0, 65535));
      write_reg(sbrcd_pkg::REG_BASE_THREE, $urandom_range(0, 65535));
      write_reg(sbrcd_pkg::REG_BASE_FOUR, $urandom_range(0, 65535));
    end
    write_reg(sbrcd_pkg::REG_FM_SEL, ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5)
                                                                 : $urandom_range(0, 255));
    write_reg(sbrcd_pkg::REG_FORCE_SEC, $urandom_range(0, 1));
    write_reg(sbrcd_pkg::REG_FIRST_CHIPS, ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                                      : $urandom_range(0, 255));
  endtask

  // reset configuration: single chip window, mirror, FM slot, fold edges, flush cases
  task automatic test_single_chip_defaults();
    send_access(sbrcd_pkg::REQ_READ, 16'hD400, 8'h00, 32'd0);
    send_access(sbrcd_pkg::REQ_WRITE, 16'hD41E, 8'hFF, 32'd10);
    send_access(sbrcd_pkg::REQ_WRITE, 16'hD41F, 8'h5A, 32'd10);
    send_access(sbrcd_pkg::REQ_READ, sbrcd_pkg::MIRROR_LO, 8'h00, 32'd65545);
    send_access(sbrcd_pkg::REQ_WRITE, sbrcd_pkg::MIRROR_HI, 8'hA5, 32'd131081);
    send_access(sbrcd_pkg::REQ_READ, 16'hD5E0, 8'h00, 32'd262151);
    send_access(sbrcd_pkg::REQ_FLUSH, 16'h0000, 8'h00, 32'd262251);
    send_access(sbrcd_pkg::REQ_FLUSH, 16'h0000, 8'h00, 32'd262251);
    send_access(sbrcd_pkg::REQ_WRITE, sbrcd_pkg::FM_ADDR_A, 8'h11, 32'd262256);
    send_access(sbrcd_pkg::REQ_READ, sbrcd_pkg::FM_ADDR_B, 8'h00, 32'd262257);
    send_access(sbrcd_pkg::REQ_WRITE, 16'h0000, 8'h3C, 32'hFFFF_FFFF);
    send_access(sbrcd_pkg::REQ_FLUSH, 16'hFFFF, 8'h00, 32'd3);
    send_access(sbrcd_pkg::REQ_RSVD, 16'hD400, 8'hFF, 32'h8000_0000);
    send_access(sbrcd_pkg::REQ_READ, 16'hFFFF, 8'h00, 32'h8000_0000);
    wait_results_done();
  endtask

  // socket offsets, four windows with overlap and top-of-space bounds, unused counts
  task automatic test_decode_modes();
    write_reg(sbrcd_pkg::REG_FORCE_SEC, 1);
    send_access(sbrcd_pkg::REQ_WRITE, 16'hD405, 8'h01, bus_cycle + 7);
    wait_results_done();
    write_reg(sbrcd_pkg::REG_FIRST_CHIPS, 2);
    send_access(sbrcd_pkg::REQ_WRITE, 16'hD5C3, 8'h02, bus_cycle + 7);
    wait_results_done();
    write_reg(sbrcd_pkg::REG_FIRST_CHIPS, 255);
    send_access(sbrcd_pkg::REQ_READ, 16'hD41D, 8'h00, bus_cycle + 1);
    wait_results_done();
    write_reg(sbrcd_pkg::REG_CHIP_COUNT, 4);
    write_reg(sbrcd_pkg::REG_BASE_ONE, 32'h0000);
    write_reg(sbrcd_pkg::REG_BASE_TWO, 32'h0010);
    write_reg(sbrcd_pkg::REG_BASE_THREE, 32'hFFF0);
    write_reg(sbrcd_pkg::REG_BASE_FOUR, 32'hFFFF);
    write_reg(sbrcd_pkg::REG_FM_SEL, 4);
    send_access(sbrcd_pkg::REQ_WRITE, 16'h0010, 8'h03, bus_cycle + 2);
    send_access(sbrcd_pkg::REQ_WRITE, 16'h0020, 8'h04, bus_cycle + 2);
    send_access(sbrcd_pkg::REQ_WRITE, 16'hFFFF, 8'h05, bus_cycle + 2);
    send_access(sbrcd_pkg::REQ_WRITE, sbrcd_pkg::FM_ADDR_A, 8'h06, bus_cycle + 2);
    wait_results_done();
    write_reg(sbrcd_pkg::REG_CHIP_COUNT, 7);
    write_reg(sbrcd_pkg::REG_FM_SEL, 255);
    send_access(sbrcd_pkg::REQ_WRITE, 16'h0000, 8'h07, bus_cycle + 3);
    send_access(sbrcd_pkg::REQ_WRITE, sbrcd_pkg::FM_ADDR_B, 8'h08, bus_cycle + 3);
    wait_results_done();
    write_reg(sbrcd_pkg::REG_CHIP_COUNT, 0);
    send_access(sbrcd_pkg::REQ_READ, 16'h0000, 8'h00, bus_cycle + 4);
    wait_results_done();
  endtask

  task automatic test_random_phase(input int s_pct, input int r_pct, input int n_sets,
                                   input int n_items);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_sets) begin
      wait_results_done();
      write_random_config();
      send_random(n_items);
    end
    wait_results_done();
  endtask

  // output held off long while requests keep coming, so the input backs up
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_results_done();
    hold_tog <= ~hold_tog;
    send_random(40);
    wait_results_done();
  endtask

  // writes, a full drain with the sender paused, then a flush and one more write
  task automatic test_flush_after_pause();
    write_reg(sbrcd_pkg::REG_CHIP_COUNT, 1);
    write_reg(sbrcd_pkg::REG_BASE_ONE, 32'hD400);
    write_reg(sbrcd_pkg::REG_FORCE_SEC, 0);
    send_access(sbrcd_pkg::REQ_WRITE, 16'hD401, 8'h10, bus_cycle + 20);
    send_access(sbrcd_pkg::REQ_WRITE, 16'hD402, 8'h20, bus_cycle + 70000);
    wait_results_done();
    send_access(sbrcd_pkg::REQ_FLUSH, 16'h0000, 8'h00, bus_cycle + 500);
    send_access(sbrcd_pkg::REQ_WRITE, 16'hD403, 8'h30, bus_cycle + 1);
    wait_results_done();
  endtask

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= sbrcd_pkg::REQ_READ;
    req_ch.bus_address <= '0;
    req_ch.write_value <= '0;
    req_ch.cycle_now   <= '0;
    cfg_chips       = sbrcd_pkg::RST_CHIP_COUNT;
    cfg_base[0]     = sbrcd_pkg::RST_BASE_ONE;
    cfg_base[1]     = sbrcd_pkg::RST_BASE_TWO;
    cfg_base[2]     = sbrcd_pkg::RST_BASE_THREE;
    cfg_base[3]     = sbrcd_pkg::RST_BASE_FOUR;
    cfg_fm_sel      = sbrcd_pkg::RST_FM_SEL;
    cfg_force_sec   = sbrcd_pkg::RST_FORCE_SEC;
    cfg_first_chips = sbrcd_pkg::RST_FIRST_CHIPS;
    prev_cycle      = '0;
    cur_chip        = '0;
    wrote_delay     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_chip_defaults();
    test_decode_modes();
    test_random_phase(15, 84, 6, 100);
    test_random_phase(84, 15, 6, 100);
    test_random_phase(0, 0, 6, 100);
    test_output_stall();
    test_flush_after_pause();
    wait_results_done();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sbrcd_pkg.sv
hw/rtl/sbrcd_ifs.sv
hw/rtl/sbrcd_regs.sv
hw/rtl/sbrcd_front.sv
hw/rtl/sbrcd_fifo.sv
hw/rtl/sbrcd_back.sv
hw/rtl/sid_bus_remap_and_cycle_delay.sv
tb/tb_top.sv
